// ===== src/viterbi_duration_vad_top_defines.svh =====
// assertion macros shared by the checker of the voice activity detector
// no dependencies
`ifndef VITERBI_DURATION_VAD_TOP_DEFINES_SVH
`define VITERBI_DURATION_VAD_TOP_DEFINES_SVH

// checked only while out of reset
`define VVAD_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vvad check failed");

// checked also during reset, in the cycle after the antecedent
`define VVAD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("vvad reset check failed");

`endif

// ===== src/vvad_pkg.sv =====
// types, constants and codes of the voice activity detector
// no dependencies
package vvad_pkg;

    localparam int MAX_DUR   = 64;
    localparam int MAX_LOOK  = 64;
    localparam int SCORE_W   = 24;
    localparam int NST       = 2 * MAX_DUR;
    localparam int ST_W      = $clog2(NST);
    localparam int COL_W     = $clog2(MAX_LOOK);
    localparam int LN_W      = 13;
    localparam int LL_W      = LN_W + 1;
    localparam int PEN_W     = 16;
    localparam int RAW_W     = SCORE_W + 2;
    localparam int CFG_W     = 16;
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 3;
    localparam int X_W       = 16;
    localparam int FIDX_W    = 32;
    localparam int LN2_Q16   = 45426;
    localparam int LN_ZERO   = -4096;

    localparam logic [IDX_W-1:0] CFG_LOOK    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_MIN_SIL = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MIN_SP  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_PRI_SIL = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PRI_SP  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_PEN     = 3'd5;

    typedef struct packed {
        logic            eod;
        logic [X_W-1:0]  x;
    } t_item;

    typedef struct packed {
        logic                    [CNT_W-1:0] look;
        logic                    [CNT_W-1:0] nsil;
        logic                    [CNT_W-1:0] nsp;
        logic signed [LN_W-1:0]              pri_sil;
        logic signed [LN_W-1:0]              pri_sp;
        logic signed [PEN_W-1:0]             pen;
    } t_cfg;

    // front to back: head of the queue
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_fq;

    // back to front: pop and clear status
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bq;

    typedef enum logic [3:0] {
        BK_CLEAR, BK_IDLE, BK_LOG0, BK_LOG0W, BK_LOG1, BK_LOG1W,
        BK_PES0, BK_PES1, BK_FWD, BK_NORM, BK_TB_RD, BK_TB_DAT, BK_OUT
    } t_bk_st;

    typedef enum logic [2:0] {
        LG_IDLE, LG_SQ, LG_MUL, LG_RND, LG_DONE
    } t_lg_st;

endpackage

// ===== src/vvad_ram.sv =====
// generic simple dual port ram, registered read
// no dependencies
module vvad_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/vvad_log.sv =====
// iterative natural log of a q1.16 value, result signed q4.8
// depends on vvad_pkg
module vvad_log (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vvad_pkg::X_W:0]       i_v,
    output logic                         o_done,
    output logic signed [vvad_pkg::LN_W-1:0] o_ln
);
    import vvad_pkg::*;

    t_lg_st              r_st, n_st;
    logic [X_W:0]        r_m;
    logic [4:0]          r_k;
    logic [11:0]         r_f;
    logic [3:0]          r_cnt;
    logic [32:0]         r_prod;
    logic signed [LN_W-1:0] r_res;

    logic [4:0]          k;
    logic [2*X_W+1:0]    sq;
    logic [X_W+1:0]      sqs;
    logic [X_W:0]        mag;
    logic [32:0]         rnd;

    always_comb begin
        k = '0;
        for (int j = 0; j <= X_W; j++) begin
            if (i_v[j]) k = 5'(j);
        end
    end

    assign sq  = r_m * r_m;
    assign sqs = sq[2*X_W+1:X_W];
    assign mag = {5'd16 - r_k, 12'b0} - {5'b0, r_f};
    assign rnd = r_prod + 33'(1 << 19);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= LG_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            LG_IDLE: if (i_start) n_st = (i_v == '0) ? LG_DONE : LG_SQ;
            LG_SQ:   if (r_cnt == 4'd11) n_st = LG_MUL;
            LG_MUL:  n_st = LG_RND;
            LG_RND:  n_st = LG_DONE;
            LG_DONE: n_st = LG_IDLE;
            default: n_st = LG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            LG_IDLE: begin
                r_m   <= i_v << (5'd16 - k);
                r_k   <= k;
                r_f   <= '0;
                r_cnt <= '0;
                r_res <= LN_W'(LN_ZERO);
            end
            LG_SQ: begin
                if (sqs[X_W+1]) begin
                    r_m <= sqs[X_W+1:1];
                    r_f <= {r_f[10:0], 1'b1};
                end else begin
                    r_m <= sqs[X_W:0];
                    r_f <= {r_f[10:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
            end
            LG_MUL: r_prod <= 33'(mag * 17'(LN2_Q16));
            LG_RND: r_res <= -$signed({1'b0, rnd[31:20]});
            default: ;
        endcase
    end

    assign o_done = (r_st == LG_DONE);
    assign o_ln   = r_res;
endmodule

// ===== src/vvad_front.sv =====
// front end: takes items, sorts frames from flushes, two entry queue
// depends on vvad_pkg
module vvad_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [vvad_pkg::X_W-1:0] i_x,
    input  logic                   i_eod,
    input  vvad_pkg::t_bq          i_bq,
    output vvad_pkg::t_fq          o_fq
);
    import vvad_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_item      item;

    assign o_ready = (r_cnt != 2'd2) && !i_bq.clearing;
    assign push    = i_valid && o_ready;
    assign pop     = i_bq.pop && (r_cnt != 2'd0);

    // a flush item carries no sample
    assign item.eod = i_eod;
    assign item.x   = i_eod ? '0 : i_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_q[r_wp] <= item;
    end

    assign o_fq.valid = (r_cnt != 2'd0);
    assign o_fq.item  = r_q[r_rp];
endmodule

// ===== src/vvad_back.sv =====
// back end: log likelihoods, viterbi step, traceback and result register
// depends on vvad_pkg, vvad_log, vvad_ram
module vvad_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vvad_pkg::t_cfg              i_cfg,
    input  vvad_pkg::t_fq               i_fq,
    output vvad_pkg::t_bq               o_bq,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_speech,
    output logic [vvad_pkg::FIDX_W-1:0] o_frame_index,
    output logic                        o_last
);
    import vvad_pkg::*;

    t_bk_st                  r_st, n_st;
    logic [ST_W:0]           r_i;
    t_item                   r_item;
    logic signed [LL_W-1:0]  r_lsil, r_lsp;
    logic signed [SCORE_W-1:0] r_ps_es, r_prev;
    logic signed [RAW_W-1:0] r_mx;
    logic [ST_W-1:0]         r_best, r_t;
    logic [COL_W-1:0]        r_head, r_c;
    logic [CNT_W-1:0]        r_fb, r_rem;
    logic [FIDX_W-1:0]       r_fc;
    logic                    r_last;
    logic                    r_ov, r_ospeech, r_olast;
    logic [FIDX_W-1:0]       r_oidx;

    logic                    lg_start, lg_done;
    logic [X_W:0]            lg_v;
    logic signed [LN_W-1:0]  lg_ln;

    logic                    ps_we;
    logic [ST_W-1:0]         ps_wa, ps_ra;
    logic signed [SCORE_W-1:0] ps_wd, ps_rd;
    logic                    raw_we;
    logic signed [RAW_W-1:0] raw_rd;
    logic                    bp_we;
    logic [ST_W-1:0]         bp_wd, bp_rd, bp_val;
    logic [COL_W+ST_W-1:0]   bp_ra;

    logic [ST_W:0]           n_all, im1;
    logic [ST_W-1:0]         i7, es, el, s7;
    logic signed [LL_W-1:0]  cls;
    logic signed [RAW_W-1:0] a, b, raw;
    logic signed [RAW_W:0]   d;
    logic [COL_W-1:0]        head_nx, c_dec;
    logic [CNT_W-1:0]        fb_inc;
    logic                    out_free;

    assign s7    = i_cfg.nsil[ST_W-1:0];
    assign n_all = {1'b0, i_cfg.nsil} + {1'b0, i_cfg.nsp};
    assign es    = ST_W'(n_all - 1'b1);
    assign el    = s7 - 1'b1;
    assign im1   = r_i - 1'b1;
    assign i7    = im1[ST_W-1:0];
    assign cls   = (i7 < s7) ? r_lsil : r_lsp;

    // candidate scores of the current state; heads of a chain have two
    always_comb begin
        a      = RAW_W'(cls) + RAW_W'(ps_rd);
        b      = RAW_W'(cls) + RAW_W'(i_cfg.pen)
               + RAW_W'((i7 == '0) ? r_ps_es : r_prev);
        raw    = RAW_W'(cls) + RAW_W'(r_prev);
        bp_val = i7 - 1'b1;
        if (i7 == '0) begin
            raw    = (a >= b) ? a : b;
            bp_val = (a >= b) ? '0 : es;
        end else if (i7 == s7) begin
            raw    = (a >= b) ? a : b;
            bp_val = (a >= b) ? s7 : el;
        end
    end

    assign d       = (RAW_W+1)'(raw_rd) - (RAW_W+1)'(r_mx);
    assign head_nx = (r_head == COL_W'(MAX_LOOK - 1)) ? '0 : r_head + 1'b1;
    assign c_dec   = (r_c == '0) ? COL_W'(MAX_LOOK - 1) : r_c - 1'b1;
    assign fb_inc  = r_fb + 1'b1;
    assign out_free = !r_ov || i_ready;

    vvad_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lg_start),
        .i_v     (lg_v),
        .o_done  (lg_done),
        .o_ln    (lg_ln)
    );

    vvad_ram #(.W(SCORE_W), .D(NST)) u_ps (
        .i_clk(i_clk), .i_we(ps_we), .i_waddr(ps_wa), .i_wdata(ps_wd),
        .i_raddr(ps_ra), .o_rdata(ps_rd)
    );

    vvad_ram #(.W(RAW_W), .D(NST)) u_raw (
        .i_clk(i_clk), .i_we(raw_we), .i_waddr(i7), .i_wdata(raw),
        .i_raddr(r_i[ST_W-1:0]), .o_rdata(raw_rd)
    );

    vvad_ram #(.W(ST_W), .D(NST * MAX_LOOK)) u_bp (
        .i_clk(i_clk), .i_we(bp_we), .i_waddr({r_head, i7}), .i_wdata(bp_wd),
        .i_raddr(bp_ra), .o_rdata(bp_rd)
    );

    always_comb begin
        n_st     = r_st;
        lg_start = 1'b0;
        lg_v     = {1'b0, r_item.x};
        ps_we    = 1'b0;
        ps_wa    = r_i[ST_W-1:0];
        ps_wd    = '0;
        ps_ra    = r_i[ST_W-1:0];
        raw_we   = 1'b0;
        bp_we    = 1'b0;
        bp_wd    = (im1 < n_all) ? bp_val : '0;
        bp_ra    = {c_dec, r_t};
        o_bq.pop      = 1'b0;
        o_bq.clearing = (r_st == BK_CLEAR);
        case (r_st)
            BK_CLEAR: begin
                ps_we = 1'b1;
                if (r_i == ST_W'(NST - 1)) n_st = BK_IDLE;
            end
            BK_IDLE: begin
                o_bq.pop = i_fq.valid;
                if (i_fq.valid) begin
                    if (!i_fq.item.eod)    n_st = BK_LOG0;
                    else if (r_fb != '0)   n_st = BK_TB_RD;
                end
            end
            BK_LOG0: begin
                lg_start = 1'b1;
                n_st     = BK_LOG0W;
            end
            BK_LOG0W: if (lg_done) n_st = BK_LOG1;
            BK_LOG1: begin
                lg_start = 1'b1;
                lg_v     = (X_W+1)'(1 << X_W) - {1'b0, r_item.x};
                n_st     = BK_LOG1W;
            end
            BK_LOG1W: if (lg_done) n_st = BK_PES0;
            BK_PES0: begin
                ps_ra = es;
                n_st  = BK_PES1;
            end
            BK_PES1: n_st = BK_FWD;
            BK_FWD: begin
                raw_we = (r_i != '0) && (im1 < n_all);
                bp_we  = (r_i != '0);
                if (r_i == (ST_W+1)'(NST)) n_st = BK_NORM;
            end
            BK_NORM: begin
                ps_we = (r_i != '0);
                ps_wa = i7;
                ps_wd = (d < -(RAW_W+1)'(1 << (SCORE_W - 1)))
                      ? SCORE_W'(-(1 << (SCORE_W - 1))) : d[SCORE_W-1:0];
                if (r_i == n_all) n_st = (fb_inc >= i_cfg.look) ? BK_TB_RD : BK_IDLE;
            end
            BK_TB_RD:  n_st = (r_rem == '0) ? BK_OUT : BK_TB_DAT;
            BK_TB_DAT: n_st = BK_TB_RD;
            BK_OUT:    if (out_free) n_st = BK_IDLE;
            default:   n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= BK_CLEAR;
            r_i    <= '0;
            r_best <= '0;
            r_head <= '0;
            r_fb   <= '0;
            r_fc   <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == BK_OUT && out_free) r_ov <= 1'b1;
            else if (i_ready)               r_ov <= 1'b0;
            case (r_st)
                BK_CLEAR: r_i <= r_i + 1'b1;
                BK_IDLE: begin
                    r_i    <= '0;
                    r_t    <= r_best;
                    r_c    <= r_head;
                    r_rem  <= r_fb - 1'b1;
                    r_last <= (r_fb == CNT_W'(1));
                    if (i_fq.valid) r_item <= i_fq.item;
                end
                BK_LOG0W: if (lg_done) r_lsil <= LL_W'(lg_ln) - LL_W'(i_cfg.pri_sil);
                BK_LOG1W: if (lg_done) r_lsp  <= LL_W'(lg_ln) - LL_W'(i_cfg.pri_sp);
                BK_PES1:  r_ps_es <= ps_rd;
                BK_FWD: begin
                    r_prev <= ps_rd;
                    if (r_i != '0 && im1 < n_all) begin
                        if (i7 == '0) begin
                            r_mx   <= raw;
                            r_best <= '0;
                        end else if (raw > r_mx) begin
                            r_mx   <= raw;
                            r_best <= i7;
                        end
                    end
                    r_i <= (r_i == (ST_W+1)'(NST)) ? '0 : r_i + 1'b1;
                end
                BK_NORM: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == n_all) begin
                        r_head <= head_nx;
                        r_fb   <= fb_inc;
                        r_fc   <= r_fc + 1'b1;
                        r_t    <= r_best;
                        r_c    <= head_nx;
                        r_rem  <= r_fb;
                        r_last <= 1'b0;
                    end
                end
                BK_TB_RD: begin
                    if (r_rem != '0) begin
                        r_c   <= c_dec;
                        r_rem <= r_rem - 1'b1;
                    end
                end
                BK_TB_DAT: r_t <= bp_rd;
                BK_OUT: begin
                    if (out_free) begin
                        r_ospeech <= (r_t >= s7);
                        r_oidx    <= r_fc - FIDX_W'(r_fb);
                        r_olast   <= r_last;
                        r_fb      <= r_fb - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_speech      = r_ospeech;
    assign o_frame_index = r_oidx;
    assign o_last        = r_olast;
endmodule

// ===== src/viterbi_duration_vad_top.sv =====
// top level of the minimum duration viterbi voice activity detector
// depends on vvad_pkg, vvad_front, vvad_back
//
// usage
// - input channel s_axis: one item per frame, tdata holds the q0.16 silence
//   posterior, tuser high marks a flush item (no frame, drain one decision)
// - output channel m_axis: one decision item, tdata holds speech flag and
//   the frame number, tlast marks the flush that drained the last decision
// - config port: write enable, register index, data; the user writes it only
//   while idle, which the block does not enforce
// - a frame item runs the log unit (two logs), one pass over all 128 states
//   and one over the n live states, n = silence plus speech states, then
//   traceback through the read and data states per column when it releases
//   a decision; a flush item runs the traceback only when decisions pend
// - a frame gives a decision once lookahead frames are pending, lagging by
//   the lookahead less one; a flush gives one decision or none when nothing pends
// - after reset the score ram is cleared over all 128 states, s_axis_tready
//   is low during that sweep
// - a stalled output holds its item; the two entry input queue keeps
//   taking items until it fills
module viterbi_duration_vad_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // silence_probability
    input  logic                              s_axis_tuser,  // end_of_data
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,  // speech, frame_index, zero pad
    output logic                              m_axis_tlast,  // last
    input  logic                              i_cfg_we,
    input  logic [vvad_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [vvad_pkg::CFG_W-1:0]        i_cfg_data
);
    import vvad_pkg::*;

    // raw configuration registers
    logic [CNT_W-1:0]        r_look, r_nsil, r_nsp;
    logic signed [LN_W-1:0]  r_pri_sil, r_pri_sp;
    logic signed [PEN_W-1:0] r_pen;

    t_cfg  cfg;
    t_fq   fq;
    t_bq   bq;
    logic  speech;
    logic [FIDX_W-1:0] frame_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look    <= CNT_W'(50);
            r_nsil    <= CNT_W'(20);
            r_nsp     <= CNT_W'(20);
            r_pri_sil <= LN_W'(-57);
            r_pri_sp  <= LN_W'(-412);
            r_pen     <= PEN_W'(-10240);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOOK:    r_look    <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_SIL: r_nsil    <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_SP:  r_nsp     <= i_cfg_data[CNT_W-1:0];
                CFG_PRI_SIL: r_pri_sil <= i_cfg_data[LN_W-1:0];
                CFG_PRI_SP:  r_pri_sp  <= i_cfg_data[LN_W-1:0];
                CFG_PEN:     r_pen     <= i_cfg_data[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp durations and lookahead into their usable ranges
    always_comb begin
        cfg.look    = (r_look == '0) ? CNT_W'(1)
                    : (r_look > CNT_W'(MAX_LOOK)) ? CNT_W'(MAX_LOOK) : r_look;
        cfg.nsil    = (r_nsil == '0) ? CNT_W'(1)
                    : (r_nsil > CNT_W'(MAX_DUR)) ? CNT_W'(MAX_DUR) : r_nsil;
        cfg.nsp     = (r_nsp == '0) ? CNT_W'(1)
                    : (r_nsp > CNT_W'(MAX_DUR)) ? CNT_W'(MAX_DUR) : r_nsp;
        cfg.pri_sil = r_pri_sil;
        cfg.pri_sp  = r_pri_sp;
        cfg.pen     = r_pen;
    end

    // front end queue
    vvad_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata),
        .i_eod   (s_axis_tuser),
        .i_bq    (bq),
        .o_fq    (fq)
    );

    // viterbi engine and output register
    vvad_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_fq          (fq),
        .o_bq          (bq),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_speech      (speech),
        .o_frame_index (frame_index),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, frame_index, speech};
endmodule

// ===== src/vvad_chk.sv =====
// port level checker of the voice activity detector, bound to the top level
// depends on vvad_pkg and viterbi_duration_vad_top_defines.svh
`include "viterbi_duration_vad_top_defines.svh"
module vvad_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [15:0]                 s_axis_tdata,
    input logic                        s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [39:0]                 m_axis_tdata,
    input logic                        m_axis_tlast,
    input logic                        i_cfg_we,
    input logic [vvad_pkg::IDX_W-1:0]  i_cfg_idx,
    input logic [vvad_pkg::CFG_W-1:0]  i_cfg_data
);
    // a stalled decision holds
    `VVAD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    // pad bits stay zero
    `VVAD_ASSERT(a_pad_zero, m_axis_tvalid, m_axis_tdata[39:33] == 7'b0)
    // reset starts the clearing sweep with nothing on the output
    `VVAD_ASSERT_NEXT(a_reset_quiet, !i_rst_n, !s_axis_tready && !m_axis_tvalid)
endmodule

bind viterbi_duration_vad_top vvad_chk u_chk (.*);
